// ===== hdl/mes_pkg.sv =====
// ----------------------------------------------------------------------------
// mes_pkg
// Types, codes and defaults shared by the median store modules.
// ----------------------------------------------------------------------------
package mes_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_EXTRACT = 2'd1;
  localparam logic [1:0] FUNC_DUMP    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               last;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [2:0] {
    RA_I    = 3'd0,
    RA_M    = 3'd1,
    RA_JDM1 = 3'd2,
    RA_JDP1 = 3'd3,
    RA_JD   = 3'd4
  } raddr_sel_e;

  typedef struct packed {
    logic       ins;
    logic       resp_set;
    logic [1:0] resp_code;
    logic       resp_emit;
    logic       init_sort;
    logic       t_load_j;
    logic       sort_shift;
    logic       sort_place;
    logic       ex_init;
    logic       ex_shift;
    logic       ex_done;
    logic       dump_init;
    logic       dump_emit;
    raddr_sel_e raddr_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic i_ge_cnt;
    logic gt;
    logic j_is1;
    logic m_p1_lt;
    logic j_p2_lt;
    logic j_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/mes_ram.sv =====
// ----------------------------------------------------------------------------
// mes_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mes_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mes_ctrl.sv =====
// ----------------------------------------------------------------------------
// mes_ctrl
// Sequencer for insert, sort-and-extract and dump operations.
// ----------------------------------------------------------------------------
module mes_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    func_i,
  output logic          in_stall_o,
  input  mes_pkg::sts_t sts_i,
  output mes_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    IDLE  = 11'b00000000001,
    S_CHK = 11'b00000000010,
    S_WT  = 11'b00000000100,
    S_CMP = 11'b00000001000,
    S_PUT = 11'b00000010000,
    E_MED = 11'b00000100000,
    E_SH  = 11'b00001000000,
    E_OUT = 11'b00010000000,
    D_WT  = 11'b00100000000,
    R_OUT = 11'b01000000000,
    S_SPR = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.raddr_sel = mes_pkg::RA_JD;
    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            mes_pkg::FUNC_INSERT: begin
              if (sts_i.full) begin
                cmd_o.resp_set  = 1'b1;
                cmd_o.resp_code = mes_pkg::ST_FULL;
                state_d = R_OUT;
              end else begin
                cmd_o.ins = 1'b1;
              end
            end
            mes_pkg::FUNC_EXTRACT: begin
              if (sts_i.empty) begin
                cmd_o.resp_set  = 1'b1;
                cmd_o.resp_code = mes_pkg::ST_EMPTY;
                state_d = R_OUT;
              end else begin
                cmd_o.init_sort = 1'b1;
                state_d = S_CHK;
              end
            end
            mes_pkg::FUNC_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.resp_set  = 1'b1;
                cmd_o.resp_code = mes_pkg::ST_EMPTY;
                state_d = R_OUT;
              end else begin
                cmd_o.dump_init = 1'b1;
                state_d = D_WT;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (sts_i.i_ge_cnt) begin
          cmd_o.raddr_sel = mes_pkg::RA_M;
          state_d = E_MED;
        end else begin
          cmd_o.raddr_sel = mes_pkg::RA_I;
          state_d = S_WT;
        end
      end
      S_WT: begin
        cmd_o.t_load_j  = 1'b1;
        cmd_o.raddr_sel = mes_pkg::RA_JDM1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.gt) begin
          cmd_o.sort_shift = 1'b1;
          cmd_o.raddr_sel  = mes_pkg::RA_JDM1;
          if (sts_i.j_is1) begin
            state_d = S_PUT;
          end
        end else begin
          cmd_o.sort_place = 1'b1;
          state_d = S_CHK;
        end
      end
      S_PUT: begin
        cmd_o.sort_place = 1'b1;
        state_d = S_CHK;
      end
      E_MED: begin
        cmd_o.ex_init   = 1'b1;
        cmd_o.raddr_sel = mes_pkg::RA_JDP1;
        state_d = sts_i.m_p1_lt ? E_SH : E_OUT;
      end
      E_SH: begin
        cmd_o.ex_shift  = 1'b1;
        cmd_o.raddr_sel = mes_pkg::RA_JDP1;
        if (!sts_i.j_p2_lt) begin
          state_d = E_OUT;
        end
      end
      E_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.ex_done = 1'b1;
          state_d = IDLE;
        end
      end
      D_WT: begin
        if (sts_i.out_free) begin
          cmd_o.dump_emit = 1'b1;
          if (sts_i.j_last) begin
            state_d = IDLE;
          end
        end
      end
      R_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.resp_emit = 1'b1;
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/mes_dp.sv =====
// ----------------------------------------------------------------------------
// mes_dp
// Store, counters and output word register of the median store.
// ----------------------------------------------------------------------------
module mes_dp #(
  parameter int unsigned CAPACITY = mes_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] value_i,
  input  mes_pkg::cmd_t      cmd_i,
  output mes_pkg::sts_t      sts_o,
  output mes_pkg::out_t      out_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_q, count_d, sorted_q, sorted_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, m;
  logic signed [31:0] t_q, med_q, rdata;
  logic [1:0] resp_q;
  mes_pkg::out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  assign m = (count_q - CW'(1)) >> 1;

  always_comb begin
    j_d = j_q;
    if (cmd_i.t_load_j) j_d = i_q;
    if (cmd_i.sort_shift) j_d = j_q - CW'(1);
    if (cmd_i.ex_init) j_d = m;
    if (cmd_i.ex_shift || cmd_i.dump_emit) j_d = j_q + CW'(1);
    if (cmd_i.dump_init) j_d = '0;
  end

  always_comb begin
    case (cmd_i.raddr_sel)
      mes_pkg::RA_I:    raddr = i_q[AW-1:0];
      mes_pkg::RA_M:    raddr = m[AW-1:0];
      mes_pkg::RA_JDM1: raddr = AW'(j_d - CW'(1));
      mes_pkg::RA_JDP1: raddr = AW'(j_d + CW'(1));
      default:          raddr = j_d[AW-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = j_q[AW-1:0];
    wdata = rdata;
    if (cmd_i.ins) begin
      we    = 1'b1;
      waddr = count_q[AW-1:0];
      wdata = value_i;
    end
    if (cmd_i.sort_shift || cmd_i.ex_shift) we = 1'b1;
    if (cmd_i.sort_place) begin
      we    = 1'b1;
      wdata = t_q;
    end
  end

  mes_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d  = count_q;
    sorted_d = sorted_q;
    i_d      = i_q;
    if (cmd_i.ins) count_d = count_q + CW'(1);
    if (cmd_i.ex_done) begin
      count_d  = count_q - CW'(1);
      sorted_d = count_q - CW'(1);
    end
    if (cmd_i.init_sort) i_d = (sorted_q == '0) ? CW'(1) : sorted_q;
    if (cmd_i.sort_place) i_d = i_q + CW'(1);
  end

  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.resp_emit) begin
      out_d = '{data: '0, last: 1'b1, status: resp_q};
      out_valid_d = 1'b1;
    end
    if (cmd_i.ex_done) begin
      out_d = '{data: med_q, last: 1'b1, status: mes_pkg::ST_OK};
      out_valid_d = 1'b1;
    end
    if (cmd_i.dump_emit) begin
      out_d = '{data: rdata, last: sts_o.j_last, status: mes_pkg::ST_OK};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sorted_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sorted_q    <= sorted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    out_q <= out_d;
    if (cmd_i.t_load_j) t_q <= rdata;
    if (cmd_i.ex_init) med_q <= rdata;
    if (cmd_i.resp_set) resp_q <= cmd_i.resp_code;
  end

  assign sts_o.full     = (count_q >= CW'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.i_ge_cnt = (i_q >= count_q);
  assign sts_o.gt       = (rdata > t_q);
  assign sts_o.j_is1    = (j_q == CW'(1));
  assign sts_o.m_p1_lt  = ({1'b0, m} + (CW+1)'(1)) < {1'b0, count_q};
  assign sts_o.j_p2_lt  = ({1'b0, j_q} + (CW+1)'(2)) < {1'b0, count_q};
  assign sts_o.j_last   = ({1'b0, j_q} + (CW+1)'(1)) == {1'b0, count_q};
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/median_extract_store_core.sv =====
// ----------------------------------------------------------------------------
// median_extract_store_core
// Bounded store of signed words with lower-median extraction and dump.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i, in_stall_o, in_i) takes one command word: insert,
// extract or dump. Output channel (out_valid_o, out_stall_i, out_o) returns
// result words with data, last and status.
// A new command is taken only while the sequencer is idle; a finished result
// may still wait in the output register meanwhile.
// Insert: no result (full store gives one status word).
// Extract: the unsorted tail is insertion-sorted into the sorted prefix, one
// RAM read and write per cycle; then the upper part is shifted down one
// entry per cycle and the median word is issued.
// Dump: one word per cycle at best, paced by the registered RAM read and by
// the receiver.
// Reset clears the count and sorted length; the store content is undefined.
// While out_stall_i is high a valid output word holds and work waits to emit.
// ----------------------------------------------------------------------------
module median_extract_store_core #(
  parameter int unsigned CAPACITY = mes_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mes_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mes_pkg::out_t out_o
);

  mes_pkg::cmd_t cmd;
  mes_pkg::sts_t sts;

  mes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (in_i.func),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mes_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.full |-> !sts.empty) else $error("store full and empty at once");
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.dump_emit |-> !sts.empty) else $error("dump word from empty store");
  a_extract_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ex_done |-> !sts.empty) else $error("extract from empty store");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ex_done || cmd.dump_emit || cmd.resp_emit) |=> out_valid_o)
    else $error("emitted word not presented");
`endif

endmodule

// ===== tb/sv/median_extract_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_extract_store_checker
// Watches both channels of the median store, predicts every result word from
// accepted commands and compares each returned word against the oldest one.
// ----------------------------------------------------------------------------
module median_extract_store_checker #(
  parameter int unsigned CAPACITY = mes_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  mes_pkg::in_t  in_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  mes_pkg::out_t out_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            words_seen_o
);

  logic signed [31:0] shadow_store [CAPACITY];
  int unsigned        shadow_count;
  mes_pkg::out_t      pending_words [$];

  task automatic report(input string what);
    fail_count_o = fail_count_o + 1;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic mes_pkg::out_t make_word(logic signed [31:0] d, logic l,
                                              logic [1:0] s);
    mes_pkg::out_t w;
    w.data = d;
    w.last = l;
    w.status = s;
    return w;
  endfunction

  // Sort ascending, take the lower median and close the gap.
  task automatic predict_extract();
    logic signed [31:0] t;
    int j;
    int m;
    for (int i = 1; i < int'(shadow_count); i++) begin
      t = shadow_store[i];
      j = i;
      while (j > 0 && shadow_store[j-1] > t) begin
        shadow_store[j] = shadow_store[j-1];
        j--;
      end
      shadow_store[j] = t;
    end
    m = (shadow_count - 1) / 2;
    pending_words.push_back(make_word(shadow_store[m], 1'b1, mes_pkg::ST_OK));
    for (int k = m; k + 1 < int'(shadow_count); k++) shadow_store[k] = shadow_store[k+1];
    shadow_count--;
  endtask

  task automatic predict_command(input mes_pkg::in_t cmd);
    case (cmd.func)
      mes_pkg::FUNC_INSERT: begin
        if (shadow_count >= CAPACITY)
          pending_words.push_back(make_word('0, 1'b1, mes_pkg::ST_FULL));
        else begin
          shadow_store[shadow_count] = cmd.value;
          shadow_count++;
        end
      end
      mes_pkg::FUNC_EXTRACT: begin
        if (shadow_count == 0)
          pending_words.push_back(make_word('0, 1'b1, mes_pkg::ST_EMPTY));
        else predict_extract();
      end
      mes_pkg::FUNC_DUMP: begin
        if (shadow_count == 0)
          pending_words.push_back(make_word('0, 1'b1, mes_pkg::ST_EMPTY));
        else
          for (int k = 0; k < int'(shadow_count); k++)
            pending_words.push_back(make_word(shadow_store[k],
                                              k + 1 == int'(shadow_count),
                                              mes_pkg::ST_OK));
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_count_o = 0;
    words_seen_o = 0;
    pending_o = 0;
    shadow_count = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        words_seen_o <= words_seen_o + 1;
        if (pending_words.size() == 0) report("result word with nothing expected");
        else begin
          mes_pkg::out_t exp_w;
          exp_w = pending_words.pop_front();
          if (out_i.data !== exp_w.data)
            report($sformatf("data %0d, expected %0d", out_i.data, exp_w.data));
          if (out_i.last !== exp_w.last)
            report($sformatf("last %0b, expected %0b", out_i.last, exp_w.last));
          if (out_i.status !== exp_w.status)
            report($sformatf("status %0d, expected %0d", out_i.status, exp_w.status));
        end
      end
      if (in_valid_i && !in_stall_i) predict_command(in_i);
      pending_o <= int'(pending_words.size());
    end
  end
endmodule

// ===== tb/sv/median_extract_store_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_extract_store_core_tb
// Drives insert, extract and dump commands into the median store under
// several idling phases; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module median_extract_store_core_tb;

  localparam int unsigned CAP = mes_pkg::CAPACITY_DEF;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  mes_pkg::in_t  in_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  mes_pkg::out_t out_o;
  int    fail_count;
  int    pending;
  int    words_seen;
  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    sent = 0;
  int    n_ins = 0;
  int    n_ext = 0;
  int    n_dump = 0;

  always #1 clk_i = ~clk_i;

  median_extract_store_core #(.CAPACITY(CAP)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o
  );

  median_extract_store_checker #(.CAPACITY(CAP)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_i(out_o),
    .fail_count_o(fail_count), .pending_o(pending), .words_seen_o(words_seen)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Valid stays high from one word to the next unless the sender idles.
  task automatic send(input logic [1:0] f, input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i.func <= f;
    in_i.value <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    case (f)
      mes_pkg::FUNC_INSERT: n_ins++;
      mes_pkg::FUNC_EXTRACT: n_ext++;
      mes_pkg::FUNC_DUMP: n_dump++;
      default: ;
    endcase
  endtask

  // Drop valid and hold until every expected word has come.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Mostly inserts with extracts, dumps and unused codes mixed in; occasional fill bursts.
  task automatic random_phase(input int n_items);
    int sel;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        for (int k = 0; k < 12; k++) send(mes_pkg::FUNC_INSERT, rand_value());
      end else if (sel < 58) send(mes_pkg::FUNC_INSERT, rand_value());
      else if (sel < 85) send(mes_pkg::FUNC_EXTRACT, rand_value());
      else if (sel < 95) send(mes_pkg::FUNC_DUMP, rand_value());
      else send(FUNC_SPARE, rand_value());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty cases, extremes, unused code, fill to full
    send(mes_pkg::FUNC_EXTRACT, 32'sd0);
    send(mes_pkg::FUNC_DUMP, 32'sd0);
    send(FUNC_SPARE, 32'sh7fffffff);
    send(mes_pkg::FUNC_INSERT, 32'sh7fffffff);
    send(mes_pkg::FUNC_INSERT, 32'sh80000000);
    send(mes_pkg::FUNC_INSERT, -32'sd1);
    send(mes_pkg::FUNC_INSERT, 32'sd0);
    send(mes_pkg::FUNC_DUMP, 32'sd0);
    send(mes_pkg::FUNC_EXTRACT, 32'sd0);
    send(mes_pkg::FUNC_DUMP, 32'sd0);
    send(mes_pkg::FUNC_EXTRACT, 32'sd0);
    send(mes_pkg::FUNC_EXTRACT, 32'sd0);
    send(mes_pkg::FUNC_EXTRACT, 32'sd0);
    send(mes_pkg::FUNC_EXTRACT, 32'sd0);
    for (int k = 0; k < CAP; k++) send(mes_pkg::FUNC_INSERT, $urandom);
    send(mes_pkg::FUNC_INSERT, 32'sh55555555);
    send(mes_pkg::FUNC_DUMP, 32'sd0);
    for (int k = 0; k < CAP; k++) send(mes_pkg::FUNC_EXTRACT, 32'sd0);
    drain();
    random_phase(24);
    send_idle_pct = 49;
    random_phase(24);
    send_idle_pct = 0;
    stall_pct = 49;
    random_phase(24);
    send_idle_pct = 38;
    stall_pct = 38;
    random_phase(24);
    drain();
    repeat (200) @(posedge clk_i);
    $display("tb: %0d commands (%0d insert, %0d extract, %0d dump), %0d result words",
             sent, n_ins, n_ext, n_dump, words_seen);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end
endmodule
